>>> src/fsc_pkg.sv
`default_nettype none
package fsc_pkg;

  localparam int unsigned CW = 12;          // converter and register width
  localparam int unsigned XW = 14;          // signed working width of the maps
  localparam int unsigned SPW = 9;          // signed width of an output span
  localparam int unsigned NW = 20;          // divider numerator / quotient width
  localparam int unsigned DW = 12;          // divider divisor width
  localparam int unsigned DIV_STEPS = NW;
  localparam int unsigned CIW = 3;          // register index width

  localparam logic [CW-1:0] A_STRAIGHT_RST   = 12'd3040;
  localparam logic [CW-1:0] A_BENT_RST       = 12'd2800;
  localparam logic [CW-1:0] B_STRAIGHT_RST   = 12'd3040;
  localparam logic [CW-1:0] B_BENT_RST       = 12'd2800;
  localparam logic [CW-1:0] GREEN_LEVEL_RST  = 12'd2920;
  localparam logic [CW-1:0] YELLOW_LEVEL_RST = 12'd2824;

  localparam logic [7:0] ANGLE_MAX  = 8'd180;
  localparam logic [7:0] ANGLE_NONE = 8'd255;

  // knee offset: floor(d * 65 / 100) = (d * KNEE_RECIP) >> KNEE_SHIFT for d < 4096
  localparam int unsigned KRW = 21;
  localparam logic [KRW-1:0] KNEE_RECIP = 21'd1363154;
  localparam int unsigned KNEE_SHIFT = 21;

  localparam logic signed [XW-1:0] ANGLE_MID  = 14'sd90;
  localparam logic signed [SPW-1:0] ANGLE_SPAN = 9'sd90;
  localparam logic signed [XW-1:0] PAN_LO     = -14'sd100;
  localparam logic signed [SPW-1:0] PAN_SPAN  = 9'sd200;
  localparam logic signed [SPW-1:0] GRIP_SPAN = 9'sd100;

  localparam logic [1:0] LED_GREEN  = 2'd0;
  localparam logic [1:0] LED_YELLOW = 2'd1;
  localparam logic [1:0] LED_RED    = 2'd2;

  typedef enum logic [CIW-1:0] {
    REG_A_STRAIGHT, REG_A_BENT, REG_B_STRAIGHT, REG_B_BENT,
    REG_GREEN_LEVEL, REG_YELLOW_LEVEL
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_ANGLE, OP_PAN, OP_GRIP
  } op_t;

  typedef struct packed {
    logic seed_rd;
    logic update;
    logic mean_ld;
    logic knee_ld;
    logic prep;
    logic mul;
    logic step;
    logic store;
    logic out_load;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_stat_t;

  typedef struct packed {
    logic [11:0]       mean_a;
    logic [11:0]       mean_b;
    logic [7:0]        bend_angle;
    logic [7:0]        servo_position;
    logic              servo_update;
    logic [1:0]        led_class;
    logic signed [7:0] pan_percent;
    logic [6:0]        grip_percent;
  } res_t;

endpackage
`default_nettype wire

>>> src/fsc_if.sv
`default_nettype none
interface fsc_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample_a;
  logic [11:0] sample_b;
  modport source (output valid, sample_a, sample_b, input ready);
  modport sink (input valid, sample_a, sample_b, output ready);
endinterface

interface fsc_out_if;
  logic              valid;
  logic              ready;
  logic [11:0]       mean_a;
  logic [11:0]       mean_b;
  logic [7:0]        bend_angle;
  logic [7:0]        servo_position;
  logic              servo_update;
  logic [1:0]        led_class;
  logic signed [7:0] pan_percent;
  logic [6:0]        grip_percent;
  modport source (output valid, mean_a, mean_b, bend_angle, servo_position, servo_update,
                  led_class, pan_percent, grip_percent, input ready);
  modport sink (input valid, mean_a, mean_b, bend_angle, servo_position, servo_update,
                led_class, pan_percent, grip_percent, output ready);
endinterface
`default_nettype wire

>>> src/flex_sensor_conditioner_unit.sv
// Flex-sensor conditioner.
// Input channel in_ch carries one transaction per sensor pair (sample_a,
// sample_b); output channel out_ch carries one result transaction per input:
// moving averages, bend angle, servo command with update flag, LED class,
// pan and grip percentages. Both are valid/ready channels.
// Calibration and thresholds sit behind a write-only port (cfg_we,
// cfg_index, cfg_data); write them only while the block is idle.
// One item is in flight at a time: a new input is taken only after the
// previous result has been loaded into the output register. Processing
// runs through a single 20-step restoring divider, shared by the three
// map divisions per item (angle, pan and grip); the averages and the knee
// come from multiplication by constant reciprocals, registered in turn.
// Reset (synchronous, active high) restores the default calibration, marks
// the ring buffer unseeded and sets the last written angle to none (255);
// the first transaction after reset seeds the whole window with its samples.
// A stalled receiver holds the result in the output register; the next input
// transaction is still accepted and processed, and waits before the output
// until the held result is taken.
`default_nettype none
module flex_sensor_conditioner_unit #(
  parameter int unsigned WINDOW = 20
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [fsc_pkg::CIW-1:0] cfg_index,
  input  wire logic [fsc_pkg::CW-1:0]  cfg_data,
  fsc_in_if.sink                       in_ch,
  fsc_out_if.source                    out_ch
);

  fsc_pkg::dp_cmd_t  cmd;
  fsc_pkg::dp_stat_t stat;
  fsc_pkg::res_t     res;

  // sequencer: accept, update the ring, averages and knee, three divisions, hand over
  fsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // ring buffer, sums, shared divider, maps and the output register
  fsc_dp #(.WINDOW(WINDOW)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_a  (in_ch.sample_a),
    .sample_b  (in_ch.sample_b),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .res       (res)
  );

  assign out_ch.mean_a         = res.mean_a;
  assign out_ch.mean_b         = res.mean_b;
  assign out_ch.bend_angle     = res.bend_angle;
  assign out_ch.servo_position = res.servo_position;
  assign out_ch.servo_update   = res.servo_update;
  assign out_ch.led_class      = res.led_class;
  assign out_ch.pan_percent    = res.pan_percent;
  assign out_ch.grip_percent   = res.grip_percent;

`ifndef ASSERT_OFF
  // one item in flight: after an accepted input, hold off the next
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is in flight");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.bend_angle <= fsc_pkg::ANGLE_MAX))
    else $error("bend angle beyond full bend");

  a_servo_inverse: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.servo_position == fsc_pkg::ANGLE_MAX - out_ch.bend_angle))
    else $error("servo command does not mirror the bend angle");

  a_led_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.led_class == fsc_pkg::LED_GREEN ||
                      out_ch.led_class == fsc_pkg::LED_YELLOW ||
                      out_ch.led_class == fsc_pkg::LED_RED))
    else $error("LED class code out of range");
`endif

endmodule
`default_nettype wire

>>> src/fsc_ctrl.sv
`default_nettype none
module fsc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fsc_pkg::dp_stat_t stat,
  output fsc_pkg::dp_cmd_t       cmd
);

  localparam int unsigned CNTW = $clog2(fsc_pkg::DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_UPDATE, S_MEAN, S_KNEE, S_PREP, S_MUL, S_DIV, S_STORE, S_OUT
  } state_t;

  state_t          state;
  fsc_pkg::op_t    op;
  logic [CNTW-1:0] cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.seed_rd  = (state == S_IDLE) && in_valid;
    cmd.update   = (state == S_UPDATE);
    cmd.mean_ld  = (state == S_MEAN);
    cmd.knee_ld  = (state == S_KNEE);
    cmd.prep     = (state == S_PREP);
    cmd.mul      = (state == S_MUL);
    cmd.step     = (state == S_DIV);
    cmd.store    = (state == S_STORE);
    cmd.out_load = (state == S_OUT) && !stat.out_full;
    cmd.op       = op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= fsc_pkg::OP_ANGLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_UPDATE;
        end
        S_UPDATE: begin
          op    <= fsc_pkg::OP_ANGLE;
          state <= S_MEAN;
        end
        S_MEAN: state <= S_KNEE;
        S_KNEE: state <= S_PREP;
        S_PREP: state <= S_MUL;
        S_MUL: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == CNTW'(fsc_pkg::DIV_STEPS - 1)) state <= S_STORE;
          else cnt <= cnt + 1'b1;
        end
        S_STORE: begin
          case (op)
            fsc_pkg::OP_ANGLE: op <= fsc_pkg::OP_PAN;
            fsc_pkg::OP_PAN:   op <= fsc_pkg::OP_GRIP;
            default:           op <= fsc_pkg::OP_ANGLE;
          endcase
          state <= (op == fsc_pkg::OP_GRIP) ? S_OUT : S_PREP;
        end
        S_OUT: begin
          if (!stat.out_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/fsc_dp.sv
`default_nettype none
module fsc_dp #(
  parameter int unsigned WINDOW = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fsc_pkg::CIW-1:0]       cfg_index,
  input  wire logic [fsc_pkg::CW-1:0]        cfg_data,
  input  wire logic [11:0]                   sample_a,
  input  wire logic [11:0]                   sample_b,
  input  wire fsc_pkg::dp_cmd_t              cmd,
  output fsc_pkg::dp_stat_t                  stat,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output fsc_pkg::res_t                      res
);

  localparam int unsigned PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SW = 12 + $clog2(WINDOW + 1);
  localparam int unsigned XW = fsc_pkg::XW;
  localparam int unsigned NW = fsc_pkg::NW;
  localparam int unsigned DW = fsc_pkg::DW;
  localparam int unsigned SPW = fsc_pkg::SPW;
  localparam int unsigned PRW = XW + SPW;
  localparam int unsigned CW = fsc_pkg::CW;
  // sum / WINDOW as (sum * RM) >> RK, exact for every sum below 2^SW
  localparam int unsigned LW = $clog2(WINDOW);
  localparam int unsigned RK = SW + LW;
  localparam int unsigned RMW = RK + 1;
  localparam logic [RMW-1:0] RM =
    RMW'(((64'd1 << RK) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int unsigned PMW = SW + RMW;
  localparam int unsigned KPW = CW + fsc_pkg::KRW;

  // configuration
  logic [11:0] a_straight, a_bent, b_straight, b_bent, green_level, yellow_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_straight   <= fsc_pkg::A_STRAIGHT_RST;
      a_bent       <= fsc_pkg::A_BENT_RST;
      b_straight   <= fsc_pkg::B_STRAIGHT_RST;
      b_bent       <= fsc_pkg::B_BENT_RST;
      green_level  <= fsc_pkg::GREEN_LEVEL_RST;
      yellow_level <= fsc_pkg::YELLOW_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fsc_pkg::REG_A_STRAIGHT:   a_straight   <= cfg_data;
        fsc_pkg::REG_A_BENT:       a_bent       <= cfg_data;
        fsc_pkg::REG_B_STRAIGHT:   b_straight   <= cfg_data;
        fsc_pkg::REG_B_BENT:       b_bent       <= cfg_data;
        fsc_pkg::REG_GREEN_LEVEL:  green_level  <= cfg_data;
        fsc_pkg::REG_YELLOW_LEVEL: yellow_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // ring buffer: entries not yet written since seeding read as the seed pair
  logic [23:0]   ring [WINDOW];
  logic [23:0]   rdata;
  logic [11:0]   sa, sb, seed_a, seed_b, old_a, old_b;
  logic [SW-1:0] sum_a, sum_b;
  logic [PW-1:0] pos;
  logic          seeded, full;

  assign old_a = full ? rdata[23:12] : seed_a;
  assign old_b = full ? rdata[11:0]  : seed_b;

  always_ff @(posedge clk) begin
    if (cmd.seed_rd) rdata <= ring[pos];
    if (cmd.update)  ring[pos] <= {sa, sb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= 1'b0;
      full   <= 1'b0;
      pos    <= '0;
      sum_a  <= '0;
      sum_b  <= '0;
    end else if (cmd.seed_rd) begin
      sa <= sample_a;
      sb <= sample_b;
      if (!seeded) begin
        seeded <= 1'b1;
        seed_a <= sample_a;
        seed_b <= sample_b;
        sum_a  <= SW'(sample_a) * SW'(WINDOW);
        sum_b  <= SW'(sample_b) * SW'(WINDOW);
      end
    end else if (cmd.update) begin
      sum_a <= sum_a - SW'(old_a) + SW'(sa);
      sum_b <= sum_b - SW'(old_b) + SW'(sb);
      if (pos == PW'(WINDOW - 1)) begin
        pos  <= '0;
        full <= 1'b1;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  // averages and knee: multiply by scaled reciprocals of the constant divisors
  logic [11:0]           ma, mb;
  logic signed [XW-1:0]  knee;
  logic [PMW-1:0]        mprod_a, mprod_b;
  logic signed [XW-1:0]  as_s, ab_s, kd, kd_mag;
  logic [KPW-1:0]        kprod;
  logic [11:0]           kq;
  logic                  kneg;

  assign as_s = XW'(signed'({1'b0, a_straight}));
  assign ab_s = XW'(signed'({1'b0, a_bent}));

  assign mprod_a = PMW'(sum_a) * PMW'(RM);
  assign mprod_b = PMW'(sum_b) * PMW'(RM);
  assign kd      = as_s - ab_s;
  assign kd_mag  = kd[XW-1] ? -kd : kd;
  assign kprod   = KPW'(kd_mag[CW-1:0]) * KPW'(fsc_pkg::KNEE_RECIP);

  always_ff @(posedge clk) begin
    if (cmd.mean_ld) begin
      ma   <= mprod_a[RK +: 12];
      mb   <= mprod_b[RK +: 12];
      kq   <= kprod[fsc_pkg::KNEE_SHIFT +: 12];
      kneg <= kd[XW-1];
    end
    if (cmd.knee_ld) begin
      knee <= kneg ? as_s + signed'({2'b00, kq}) : as_s - signed'({2'b00, kq});
    end
  end

  // operand preparation: clamp, offset, span and divisor
  logic signed [XW-1:0]  x, lo, hi, olo, mn, mx, xc;
  logic signed [SPW-1:0] span;
  logic signed [XW-1:0]  t_r, den_r, olo_r;
  logic signed [SPW-1:0] span_r;
  logic                  zero_r;

  always_comb begin
    x    = XW'(signed'({1'b0, ma}));
    lo   = as_s;
    hi   = ab_s;
    olo  = '0;
    span = fsc_pkg::PAN_SPAN;
    case (cmd.op)
      fsc_pkg::OP_ANGLE: begin
        span = fsc_pkg::ANGLE_SPAN;
        if (x >= knee) begin
          lo = as_s;
          hi = knee;
        end else begin
          lo  = knee;
          hi  = ab_s;
          olo = fsc_pkg::ANGLE_MID;
        end
      end
      fsc_pkg::OP_PAN: olo = fsc_pkg::PAN_LO;
      fsc_pkg::OP_GRIP: begin
        x    = XW'(signed'({1'b0, mb}));
        lo   = XW'(signed'({1'b0, b_straight}));
        hi   = XW'(signed'({1'b0, b_bent}));
        span = fsc_pkg::GRIP_SPAN;
      end
      default: ;
    endcase
    mn = (lo < hi) ? lo : hi;
    mx = (lo < hi) ? hi : lo;
    xc = (x < mn) ? mn : ((x > mx) ? mx : x);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      t_r    <= xc - lo;
      span_r <= span;
      den_r  <= hi - lo;
      olo_r  <= olo;
      zero_r <= (hi == lo);
    end
  end

  // multiply, then shared restoring divider on magnitudes
  logic signed [PRW-1:0] prod;
  logic [PRW-1:0]        prod_mag;
  logic [XW-1:0]         den_mag;
  logic [NW-1:0]         num;
  logic [DW-1:0]         den, rem;
  logic [DW:0]           shifted;
  logic                  neg;

  assign prod     = t_r * span_r;
  assign prod_mag = prod[PRW-1] ? PRW'(-prod) : PRW'(prod);
  assign den_mag  = den_r[XW-1] ? XW'(-den_r) : XW'(den_r);
  assign shifted  = {rem, num[NW-1]};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem <= '0;
      den <= den_mag[DW-1:0];
      num <= prod_mag[NW-1:0];
      neg <= prod[PRW-1] ^ den_r[XW-1];
    end else if (cmd.step) begin
      if (shifted >= {1'b0, den}) begin
        rem <= DW'(shifted - {1'b0, den});
        num <= {num[NW-2:0], 1'b1};
      end else begin
        rem <= shifted[DW-1:0];
        num <= {num[NW-2:0], 1'b0};
      end
    end
  end

  // result assembly
  logic signed [XW-1:0] q_s, mres;
  logic [7:0]           angle, last_angle;
  logic signed [7:0]    pan;
  logic [6:0]           grip;
  logic [1:0]           led;

  assign q_s  = neg ? -signed'(num[XW-1:0]) : signed'(num[XW-1:0]);
  assign mres = zero_r ? olo_r : q_s + olo_r;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.op)
        fsc_pkg::OP_ANGLE: angle <= mres[7:0];
        fsc_pkg::OP_PAN:   pan   <= mres[7:0];
        default:           grip  <= mres[6:0];
      endcase
    end
  end

  always_comb begin
    if (ma >= green_level) led = fsc_pkg::LED_GREEN;
    else if (ma >= yellow_level) led = fsc_pkg::LED_YELLOW;
    else led = fsc_pkg::LED_RED;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      last_angle <= fsc_pkg::ANGLE_NONE;
    end else if (cmd.out_load) begin
      out_valid          <= 1'b1;
      last_angle         <= angle;
      res.mean_a         <= ma;
      res.mean_b         <= mb;
      res.bend_angle     <= angle;
      res.servo_position <= fsc_pkg::ANGLE_MAX - angle;
      res.servo_update   <= (angle != last_angle);
      res.led_class      <= led;
      res.pan_percent    <= pan;
      res.grip_percent   <= grip;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.out_full = out_valid;

endmodule
`default_nettype wire

>>> tb/sv/tb_flex_sensor_conditioner_unit.sv
`default_nettype none
module tb_flex_sensor_conditioner_unit;

  localparam int WIN = 20;              // averaging window of the unit
  localparam int SETTLE = 160;          // extra wait after the unit has drained
  localparam int STALL_LIMIT = 4000;    // cycles without any transaction
  localparam int IDLE_MAX = 18;
  localparam logic [fsc_pkg::CIW-1:0] IDX_SPARE_LO = 3'd6;  // indexes past the register file
  localparam logic [fsc_pkg::CIW-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct {
    logic [11:0] a;
    logic [11:0] b;
    bit          drain_first;  // hold until every result is back
  } pair_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [fsc_pkg::CIW-1:0] cfg_index;
  logic [fsc_pkg::CW-1:0] cfg_data;

  fsc_in_if in_bus ();
  fsc_out_if out_bus ();

  flex_sensor_conditioner_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_bus), .out_ch(out_bus)
  );

  // Stimulus and expected results
  pair_t          pending_pairs[$];
  fsc_pkg::res_t  expected_results[$];
  pair_t          on_bus;

  // Own copy of the unit state and calibration
  int          cal[6];
  logic [11:0] hist_a[WIN];
  logic [11:0] hist_b[WIN];
  logic [16:0] total_a, total_b;
  int          slot;
  bit          primed;
  int          prev_angle;

  int  mismatches = 0;
  int  sent = 0;
  int  checked = 0;
  int  phases = 0;
  bit  calm = 0;       // no idling on either side while set
  int  send_gap = 0;
  int  sink_stall = 0;
  int  quiet = 0;

  // Clamped linear map, signed division truncating toward zero
  function automatic int map_clamped(int x, int lo, int hi, int olo, int ohi);
    int mn, mx;
    mn = (lo < hi) ? lo : hi;
    mx = (lo < hi) ? hi : lo;
    if (x < mn) x = mn;
    if (x > mx) x = mx;
    if (hi == lo) return olo;
    return (x - lo) * (ohi - olo) / (hi - lo) + olo;
  endfunction

  // Advance the averaging state by one sample pair and work out its result
  function automatic fsc_pkg::res_t condition_pair(logic [11:0] sa, logic [11:0] sb);
    fsc_pkg::res_t r;
    int ma, mb, knee, angle, pan, grip;
    if (!primed) begin
      for (int i = 0; i < WIN; i++) begin
        hist_a[i] = sa;
        hist_b[i] = sb;
      end
      total_a = 17'(sa * WIN);
      total_b = 17'(sb * WIN);
      slot = 0;
      primed = 1;
    end
    total_a = total_a - hist_a[slot] + sa;
    total_b = total_b - hist_b[slot] + sb;
    hist_a[slot] = sa;
    hist_b[slot] = sb;
    slot = (slot + 1 >= WIN) ? 0 : slot + 1;
    ma = int'(total_a) / WIN;
    mb = int'(total_b) / WIN;
    knee = cal[fsc_pkg::REG_A_STRAIGHT] -
           ((cal[fsc_pkg::REG_A_STRAIGHT] - cal[fsc_pkg::REG_A_BENT]) * 65) / 100;
    if (ma >= knee) angle = map_clamped(ma, cal[fsc_pkg::REG_A_STRAIGHT], knee, 0, 90);
    else angle = map_clamped(ma, knee, cal[fsc_pkg::REG_A_BENT], 90, 180);
    pan = map_clamped(ma, cal[fsc_pkg::REG_A_STRAIGHT], cal[fsc_pkg::REG_A_BENT], -100, 100);
    grip = map_clamped(mb, cal[fsc_pkg::REG_B_STRAIGHT], cal[fsc_pkg::REG_B_BENT], 0, 100);
    r.mean_a = ma[11:0];
    r.mean_b = mb[11:0];
    r.bend_angle = angle[7:0];
    r.servo_position = 8'(180 - angle);
    r.servo_update = (angle != prev_angle);
    if (ma >= cal[fsc_pkg::REG_GREEN_LEVEL]) r.led_class = fsc_pkg::LED_GREEN;
    else if (ma >= cal[fsc_pkg::REG_YELLOW_LEVEL]) r.led_class = fsc_pkg::LED_YELLOW;
    else r.led_class = fsc_pkg::LED_RED;
    r.pan_percent = pan[7:0];
    r.grip_percent = grip[6:0];
    prev_angle = angle;
    return r;
  endfunction

  task automatic compare_field(string field, int want, int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected %0d, got %0d", checked, field, want, got);
    end
  endtask

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Driver: feed pairs from the pending queue, with random gaps between transactions
  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid <= 0;
    end else if (!(in_bus.valid && !in_bus.ready)) begin
      if (in_bus.valid && in_bus.ready) begin
        expected_results.push_back(condition_pair(on_bus.a, on_bus.b));
        sent++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_bus.valid <= 0;
      end else if (pending_pairs.size() != 0 &&
                   !(pending_pairs[0].drain_first && expected_results.size() != 0)) begin
        on_bus = pending_pairs.pop_front();
        in_bus.sample_a <= on_bus.a;
        in_bus.sample_b <= on_bus.b;
        in_bus.valid <= 1;
        send_gap = calm ? 0 : $urandom_range(0, IDLE_MAX);
      end else begin
        in_bus.valid <= 0;
      end
    end
  end

  // Monitor: check each result against the oldest expectation, stall at random
  always @(posedge clk) begin
    fsc_pkg::res_t want;
    if (rst) begin
      out_bus.ready <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result arrived with nothing expected");
        end else begin
          want = expected_results.pop_front();
          compare_field("mean_a", want.mean_a, out_bus.mean_a);
          compare_field("mean_b", want.mean_b, out_bus.mean_b);
          compare_field("bend_angle", want.bend_angle, out_bus.bend_angle);
          compare_field("servo_position", want.servo_position, out_bus.servo_position);
          compare_field("servo_update", want.servo_update, out_bus.servo_update);
          compare_field("led_class", want.led_class, out_bus.led_class);
          compare_field("pan_percent", want.pan_percent, out_bus.pan_percent);
          compare_field("grip_percent", want.grip_percent, out_bus.grip_percent);
        end
        checked++;
        sink_stall = calm ? 0 : $urandom_range(0, IDLE_MAX);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_bus.ready <= 0;
      end else begin
        out_bus.ready <= 1;
      end
    end
  end

  // Watchdog: give up when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Write one register; the local calibration follows in step
  task automatic write_reg(logic [fsc_pkg::CIW-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value[11:0];
    if (idx < 6) cal[idx] = value & 12'hFFF;
  endtask

  task automatic calibrate(int as, int ab, int bs, int bb, int grn, int yel);
    write_reg(fsc_pkg::REG_A_STRAIGHT, as);
    write_reg(fsc_pkg::REG_A_BENT, ab);
    write_reg(fsc_pkg::REG_B_STRAIGHT, bs);
    write_reg(fsc_pkg::REG_B_BENT, bb);
    write_reg(fsc_pkg::REG_GREEN_LEVEL, grn);
    write_reg(fsc_pkg::REG_YELLOW_LEVEL, yel);
    @(posedge clk);
    cfg_we <= 0;
    phases++;
  endtask

  // Wait until the unit has drained, then let the datapath settle
  task automatic settle();
    while (pending_pairs.size() != 0 || expected_results.size() != 0 || in_bus.valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_pair(int a, int b, bit drain = 0);
    pair_t p;
    p.a = a[11:0];
    p.b = b[11:0];
    p.drain_first = drain;
    pending_pairs.push_back(p);
  endtask

  // Mostly samples around the calibrated span, some across the full range
  task automatic queue_random(int count);
    int lo_a, hi_a, lo_b, hi_b;
    lo_a = (cal[fsc_pkg::REG_A_STRAIGHT] < cal[fsc_pkg::REG_A_BENT]) ?
           cal[fsc_pkg::REG_A_STRAIGHT] : cal[fsc_pkg::REG_A_BENT];
    hi_a = (cal[fsc_pkg::REG_A_STRAIGHT] < cal[fsc_pkg::REG_A_BENT]) ?
           cal[fsc_pkg::REG_A_BENT] : cal[fsc_pkg::REG_A_STRAIGHT];
    lo_b = (cal[fsc_pkg::REG_B_STRAIGHT] < cal[fsc_pkg::REG_B_BENT]) ?
           cal[fsc_pkg::REG_B_STRAIGHT] : cal[fsc_pkg::REG_B_BENT];
    hi_b = (cal[fsc_pkg::REG_B_STRAIGHT] < cal[fsc_pkg::REG_B_BENT]) ?
           cal[fsc_pkg::REG_B_BENT] : cal[fsc_pkg::REG_B_STRAIGHT];
    lo_a = (lo_a > 300) ? lo_a - 300 : 0;
    lo_b = (lo_b > 300) ? lo_b - 300 : 0;
    hi_a = (hi_a < 3795) ? hi_a + 300 : 4095;
    hi_b = (hi_b < 3795) ? hi_b + 300 : 4095;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 3)
        queue_pair($urandom_range(0, 4095), $urandom_range(0, 4095), i == count / 2);
      else
        queue_pair($urandom_range(lo_a, hi_a), $urandom_range(lo_b, hi_b), i == count / 2);
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_bus.valid = 0;
    in_bus.sample_a = '0;
    in_bus.sample_b = '0;
    out_bus.ready = 0;
    cal = '{3040, 2800, 3040, 2800, 2920, 2824};
    hist_a = '{default: '0};
    hist_b = '{default: '0};
    total_a = '0;
    total_b = '0;
    slot = 0;
    primed = 0;
    prev_angle = 255;
    repeat (2) @(posedge clk);
    rst <= 0;

    // Default calibration: seed with the straight reading, then sweep the knee region,
    // the thresholds and the field extremes
    queue_pair(3040, 3040);
    queue_pair(3040, 3040);
    queue_pair(2800, 2800);
    queue_pair(2920, 2824);
    queue_pair(2824, 2919);
    queue_pair(0, 0);
    queue_pair(4095, 4095);
    queue_pair(4095, 0);
    queue_pair(0, 4095);
    queue_pair(2884, 2884);
    queue_pair(12'hAAA, 12'h555);
    queue_pair(12'h555, 12'hAAA);
    for (int i = 0; i < 8; i++) queue_pair(2700, 3100);
    queue_random(60);
    settle();

    // Spare register indexes must be ignored
    write_reg(IDX_SPARE_LO, 12'hFFF);
    write_reg(IDX_SPARE_HI, 0);
    calibrate(4095, 0, 4095, 0, 4095, 0);
    calm = 1;
    queue_pair(4095, 4095);
    queue_pair(0, 0);
    queue_random(60);
    settle();
    calm = 0;

    // Reversed calibration on both channels
    calibrate(0, 4095, 1000, 3000, 0, 4095);
    queue_random(60);
    settle();

    // Zero span: straight equals bent
    calibrate(2000, 2000, 1500, 1500, 2000, 2000);
    queue_pair(2000, 1500);
    queue_pair(1999, 1501);
    queue_random(60);
    settle();

    for (int p = 0; p < 3; p++) begin
      calibrate($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
                $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
      calm = (p == 1);
      queue_random(60);
      settle();
    end
    calm = 0;

    $display("%0d sample pairs sent across %0d calibration settings, %0d results checked",
             sent, phases + 1, checked);
    $display("covered seeding, reversed and zero spans, full-scale calibration and thresholds");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
src/fsc_pkg.sv
src/fsc_if.sv
src/fsc_ctrl.sv
src/fsc_dp.sv
src/flex_sensor_conditioner_unit.sv
tb/sv/tb_flex_sensor_conditioner_unit.sv
